@@ design/pax_pkg.sv @@
// shared types, codes and key tables of the pax header record parser
package pax_pkg;

    localparam logic [1:0] EV_TEXT   = 2'd0;
    localparam logic [1:0] EV_RECORD = 2'd1;
    localparam logic [1:0] EV_FINISH = 2'd2;

    localparam logic [2:0] KEY_PATH     = 3'd0;
    localparam logic [2:0] KEY_LINKPATH = 3'd1;
    localparam logic [2:0] KEY_UID      = 3'd2;
    localparam logic [2:0] KEY_GID      = 3'd3;
    localparam logic [2:0] KEY_SIZE     = 3'd4;
    localparam logic [2:0] KEY_MTIME    = 3'd5;
    localparam logic [2:0] KEY_CHARSET  = 3'd6;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_BAD_LENGTH = 4'd1;
    localparam logic [3:0] ERR_NO_NEWLINE = 4'd2;
    localparam logic [3:0] ERR_BAD_KEY    = 4'd3;
    localparam logic [3:0] ERR_UNKNOWN    = 4'd4;
    localparam logic [3:0] ERR_BAD_NUMBER = 4'd5;
    localparam logic [3:0] ERR_BAD_STRING = 4'd6;
    localparam logic [3:0] ERR_BAD_CHARSET = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED  = 4'd8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_DOT     = 8'h2e;

    typedef enum logic [3:0] {
        PH_LEN   = 4'b0001,
        PH_KEY   = 4'b0010,
        PH_VAL   = 4'b0100,
        PH_FAULT = 4'b1000
    } phase_t;

    // one classified input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       is_digit;
        logic       is_space;
        logic       is_newline;
        logic       is_equals;
        logic       is_dot;
        logic       is_zero;
    } cls_t;

    function automatic logic [3:0] key_len(input logic [2:0] k);
        logic [3:0] r;
        case (k)
            KEY_PATH:     r = 4'd4;
            KEY_LINKPATH: r = 4'd8;
            KEY_UID:      r = 4'd3;
            KEY_GID:      r = 4'd3;
            KEY_SIZE:     r = 4'd4;
            KEY_MTIME:    r = 4'd5;
            KEY_CHARSET:  r = 4'd10;
            default:      r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] p);
        logic [8*10-1:0] s;
        logic [7:0]      r;
        case (k)
            KEY_PATH:     s = {"path", 48'h0};
            KEY_LINKPATH: s = {"linkpath", 16'h0};
            KEY_UID:      s = {"uid", 56'h0};
            KEY_GID:      s = {"gid", 56'h0};
            KEY_SIZE:     s = {"size", 48'h0};
            KEY_MTIME:    s = {"mtime", 40'h0};
            KEY_CHARSET:  s = "hdrcharset";
            default:      s = '0;
        endcase
        if (p < 4'd10)
            r = s[8*(9 - int'(p)) +: 8];
        else
            r = 8'h00;
        return r;
    endfunction

    function automatic logic [7:0] cs_char(input logic c, input logic [2:0] p);
        logic [8*6-1:0] s;
        logic [7:0]     r;
        s = c ? {"UTF-8", 8'h0} : "BINARY";
        if (p < 3'd6)
            r = s[8*(5 - int'(p)) +: 8];
        else
            r = 8'h00;
        return r;
    endfunction

    function automatic logic [2:0] key_index(input logic [6:0] cand);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 6; i >= 0; i--)
        begin
            if (cand[i])
                r = 3'(i);
        end
        return r;
    endfunction

endpackage

@@ design/pax_in_if.sv @@
// input byte channel of the pax header parser
interface pax_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

@@ design/pax_out_if.sv @@
// result event channel of the pax header parser
interface pax_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [2:0]  key_code;
    logic [7:0]  text_byte;
    logic [63:0] record_number;
    logic [3:0]  error_code;
    logic        header_ok;

    modport source (output valid, event_kind, key_code, text_byte, record_number,
                    error_code, header_ok, input ready);
    modport sink (input valid, event_kind, key_code, text_byte, record_number,
                  error_code, header_ok, output ready);
endinterface

@@ design/pax_front.sv @@
// front end: takes input bytes and classifies them for the parser
module pax_front
(
    pax_in_if.sink          hdr,
    output pax_pkg::cls_t   item,
    output logic            item_valid,
    input  logic            item_ready
);

    always_comb
    begin
        item.data_byte  = hdr.data_byte;
        item.last_byte  = hdr.last_byte;
        item.is_digit   = (hdr.data_byte >= 8'h30) && (hdr.data_byte <= 8'h39);
        item.is_space   = hdr.data_byte == pax_pkg::CH_SPACE;
        item.is_newline = hdr.data_byte == pax_pkg::CH_NEWLINE;
        item.is_equals  = hdr.data_byte == pax_pkg::CH_EQUALS;
        item.is_dot     = hdr.data_byte == pax_pkg::CH_DOT;
        item.is_zero    = hdr.data_byte == 8'h00;
    end

    assign item_valid = hdr.valid;
    assign hdr.ready  = item_ready;

endmodule

@@ design/pax_queue.sv @@
// short queue of classified bytes between front and back
module pax_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  pax_pkg::cls_t push_item,
    input  logic          push_valid,
    output logic          push_ready,
    output pax_pkg::cls_t pop_item,
    output logic          pop_valid,
    input  logic          pop_ready
);

    pax_pkg::cls_t slot_reg [pax_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = count_reg != 2'(pax_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != 2'd0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ design/pax_back.sv @@
// back end: record parser state machine and output event register
module pax_back
#(
    parameter int LENGTH_BITS = 20
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pax_pkg::cls_t item,
    input  logic          item_valid,
    output logic          item_ready,
    pax_out_if.source     evt
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] LMAX = {LB{1'b1}};

    pax_pkg::phase_t phase_reg, phase_next;
    logic [LB-1:0] len_reg, len_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic          dig_reg, dig_next;
    logic [3:0]    kpos_reg, kpos_next;
    logic [6:0]    cand_reg, cand_next;
    logic [63:0]   acc_reg, acc_next;
    logic [LB-1:0] vlen_reg, vlen_next;
    logic          frac_reg, frac_next;
    logic [1:0]    cs_reg, cs_next;
    logic [3:0]    lerr_reg, lerr_next;

    logic          ov_reg, ov_next;
    logic [1:0]    kind_reg, kind_next;
    logic [2:0]    key_reg, key_next;
    logic [7:0]    text_reg, text_next;
    logic [63:0]   num_reg, num_next;
    logic [3:0]    oerr_reg, oerr_next;
    logic          ok_reg, ok_next;

    logic          take;
    logic [3:0]    err;
    logic          done, text_ev;
    logic [2:0]    dkey, kidx;
    logic [63:0]   dnum;
    logic [3:0]    dval;
    logic [LB+3:0] len_x10;
    logic [67:0]   acc_x10;
    logic          rec_end;
    logic [6:0]    match;
    logic [LB-1:0] vlen_inc;

    assign item_ready = !ov_reg || evt.ready;
    assign take       = item_valid && item_ready;
    assign dval       = item.data_byte[3:0];
    assign kidx       = pax_pkg::key_index(cand_reg);
    assign len_x10    = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1) + (LB+4)'(dval);
    assign acc_x10    = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 68'(dval);
    assign rec_end    = ({1'b0, pos_reg} + (LB+1)'(1)) == {1'b0, len_reg};
    assign vlen_inc   = (vlen_reg != LMAX) ? vlen_reg + LB'(1) : vlen_reg;

    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            match[i] = cand_reg[i] && (pax_pkg::key_len(3'(i)) == kpos_reg);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        dig_next   = dig_reg;
        kpos_next  = kpos_reg;
        cand_next  = cand_reg;
        acc_next   = acc_reg;
        vlen_next  = vlen_reg;
        frac_next  = frac_reg;
        cs_next    = cs_reg;
        lerr_next  = lerr_reg;
        err        = pax_pkg::ERR_NONE;
        done       = 1'b0;
        text_ev    = 1'b0;
        dkey       = 3'd0;
        dnum       = 64'd0;

        case (phase_reg)
            pax_pkg::PH_LEN:
            begin
                if (item.is_digit)
                begin
                    dig_next = 1'b1;
                    len_next = len_x10[LB-1:0];
                    if (len_x10[LB+3:LB] != 4'd0)
                        err = pax_pkg::ERR_BAD_LENGTH;
                end
                else if (item.is_space)
                begin
                    if (!dig_reg || ({2'b0, len_reg} < ({2'b0, pos_reg} + (LB+2)'(3))))
                        err = pax_pkg::ERR_BAD_LENGTH;
                    else
                        phase_next = pax_pkg::PH_KEY;
                end
                else
                begin
                    err = pax_pkg::ERR_BAD_LENGTH;
                end
                if (pos_reg != LMAX)
                    pos_next = pos_reg + LB'(1);
            end
            pax_pkg::PH_KEY, pax_pkg::PH_VAL:
            begin
                if (rec_end)
                begin
                    if (!item.is_newline)
                        err = pax_pkg::ERR_NO_NEWLINE;
                    else if (phase_reg == pax_pkg::PH_KEY)
                        err = pax_pkg::ERR_BAD_KEY;
                    else if (kidx <= pax_pkg::KEY_LINKPATH)
                    begin
                        if (vlen_reg == '0)
                            err = pax_pkg::ERR_BAD_STRING;
                    end
                    else if (kidx <= pax_pkg::KEY_MTIME)
                    begin
                        if (vlen_reg == '0)
                            err = pax_pkg::ERR_BAD_NUMBER;
                        else if (kidx == pax_pkg::KEY_MTIME && acc_reg[63])
                            err = pax_pkg::ERR_BAD_NUMBER;
                        else
                            dnum = acc_reg;
                    end
                    else
                    begin
                        if (!((cs_reg[0] && vlen_reg == LB'(6)) ||
                              (cs_reg[1] && vlen_reg == LB'(5))))
                            err = pax_pkg::ERR_BAD_CHARSET;
                    end
                    if (phase_reg == pax_pkg::PH_VAL && item.is_newline &&
                        err == pax_pkg::ERR_NONE)
                    begin
                        done       = 1'b1;
                        dkey       = kidx;
                        phase_next = pax_pkg::PH_LEN;
                        len_next   = '0;
                        pos_next   = '0;
                        dig_next   = 1'b0;
                        kpos_next  = 4'd0;
                        cand_next  = 7'h7f;
                        acc_next   = 64'd0;
                        vlen_next  = '0;
                        frac_next  = 1'b0;
                        cs_next    = 2'b11;
                    end
                    else
                    begin
                        dnum = 64'd0;
                    end
                end
                else if (phase_reg == pax_pkg::PH_KEY)
                begin
                    if (item.is_equals)
                    begin
                        if (kpos_reg == 4'd0)
                            err = pax_pkg::ERR_BAD_KEY;
                        else if (match == 7'd0)
                            err = pax_pkg::ERR_UNKNOWN;
                        else
                        begin
                            cand_next  = match;
                            phase_next = pax_pkg::PH_VAL;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            if (kpos_reg >= pax_pkg::key_len(3'(i)) ||
                                pax_pkg::key_char(3'(i), kpos_reg) != item.data_byte)
                                cand_next[i] = 1'b0;
                        end
                        if (kpos_reg != 4'd15)
                            kpos_next = kpos_reg + 4'd1;
                    end
                    pos_next = pos_reg + LB'(1);
                end
                else
                begin
                    if (kidx <= pax_pkg::KEY_LINKPATH)
                    begin
                        if (item.is_zero)
                            err = pax_pkg::ERR_BAD_STRING;
                        else
                            text_ev = 1'b1;
                        vlen_next = vlen_inc;
                    end
                    else if (kidx <= pax_pkg::KEY_MTIME)
                    begin
                        if (kidx == pax_pkg::KEY_MTIME && frac_reg)
                        begin
                            // fractional seconds are dropped
                        end
                        else if (kidx == pax_pkg::KEY_MTIME && item.is_dot)
                            frac_next = 1'b1;
                        else if (!item.is_digit || acc_x10[67:64] != 4'd0)
                            err = pax_pkg::ERR_BAD_NUMBER;
                        else
                        begin
                            acc_next  = acc_x10[63:0];
                            vlen_next = vlen_inc;
                        end
                    end
                    else
                    begin
                        for (int c = 0; c < 2; c++)
                        begin
                            if (vlen_reg >= (c == 0 ? LB'(6) : LB'(5)) ||
                                pax_pkg::cs_char(1'(c), vlen_reg[2:0]) != item.data_byte)
                                cs_next[c] = 1'b0;
                        end
                        vlen_next = vlen_inc;
                    end
                    dkey     = kidx;
                    pos_next = pos_reg + LB'(1);
                end
            end
            pax_pkg::PH_FAULT:
            begin
            end
            default:
            begin
            end
        endcase

        if (err != pax_pkg::ERR_NONE && lerr_reg == pax_pkg::ERR_NONE)
        begin
            lerr_next  = err;
            phase_next = pax_pkg::PH_FAULT;
        end

        ov_next   = ov_reg && !evt.ready;
        kind_next = kind_reg;
        key_next  = key_reg;
        text_next = text_reg;
        num_next  = num_reg;
        oerr_next = oerr_reg;
        ok_next   = ok_reg;

        if (take)
        begin
            kind_next = pax_pkg::EV_TEXT;
            key_next  = 3'd0;
            text_next = 8'd0;
            num_next  = 64'd0;
            oerr_next = pax_pkg::ERR_NONE;
            ok_next   = 1'b0;
            if (item.last_byte)
            begin
                ov_next   = 1'b1;
                kind_next = pax_pkg::EV_FINISH;
                if (lerr_next != pax_pkg::ERR_NONE)
                    oerr_next = lerr_next;
                else if (done)
                begin
                    key_next = dkey;
                    num_next = dnum;
                    ok_next  = 1'b1;
                end
                else
                    oerr_next = pax_pkg::ERR_TRUNCATED;
                // start over for the next header
                phase_next = pax_pkg::PH_LEN;
                len_next   = '0;
                pos_next   = '0;
                dig_next   = 1'b0;
                kpos_next  = 4'd0;
                cand_next  = 7'h7f;
                acc_next   = 64'd0;
                vlen_next  = '0;
                frac_next  = 1'b0;
                cs_next    = 2'b11;
                lerr_next  = pax_pkg::ERR_NONE;
            end
            else if (lerr_next == pax_pkg::ERR_NONE && done)
            begin
                ov_next   = 1'b1;
                kind_next = pax_pkg::EV_RECORD;
                key_next  = dkey;
                num_next  = dnum;
            end
            else if (lerr_next == pax_pkg::ERR_NONE && text_ev)
            begin
                ov_next   = 1'b1;
                key_next  = dkey;
                text_next = item.data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pax_pkg::PH_LEN;
            len_reg   <= '0;
            pos_reg   <= '0;
            dig_reg   <= 1'b0;
            kpos_reg  <= 4'd0;
            cand_reg  <= 7'h7f;
            acc_reg   <= 64'd0;
            vlen_reg  <= '0;
            frac_reg  <= 1'b0;
            cs_reg    <= 2'b11;
            lerr_reg  <= pax_pkg::ERR_NONE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (take)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                pos_reg   <= pos_next;
                dig_reg   <= dig_next;
                kpos_reg  <= kpos_next;
                cand_reg  <= cand_next;
                acc_reg   <= acc_next;
                vlen_reg  <= vlen_next;
                frac_reg  <= frac_next;
                cs_reg    <= cs_next;
                lerr_reg  <= lerr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        key_reg  <= key_next;
        text_reg <= text_next;
        num_reg  <= num_next;
        oerr_reg <= oerr_next;
        ok_reg   <= ok_next;
    end

    assign evt.valid         = ov_reg;
    assign evt.event_kind    = kind_reg;
    assign evt.key_code      = key_reg;
    assign evt.text_byte     = text_reg;
    assign evt.record_number = num_reg;
    assign evt.error_code    = oerr_reg;
    assign evt.header_ok     = ok_reg;

endmodule

@@ design/pax_header_record_parser.sv @@
// top level of the pax extended header record parser
// usage:
//   hdr carries the header data one byte per transfer, last_byte set on the
//   final byte. evt carries events: a path/linkpath value byte, a finished
//   record (with its number for uid, gid, size, mtime), or header finished.
//   header finished always follows the last byte; error_code there names the
//   first fault and header_ok is 1 only if every record parsed clean.
//   after a fault no events appear until the header finished event.
// timing:
//   one byte per cycle sustained while evt keeps up; a byte enters a
//   two-entry queue behind the classifier, and from the queue the back end
//   writes its event into the output register.
//   the parser back end handles one queued byte per cycle while evt keeps
//   up, limited by the record state update and the 64-bit times-ten accumulate.
// stalls and reset:
//   when evt is not taken the back end holds; the queue keeps taking bytes
//   until both entries are full, then hdr.ready drops.
//   reset empties the queue and returns the parser to the start of a header.
module pax_header_record_parser
#(
    parameter int LENGTH_BITS = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    pax_in_if.sink    hdr,
    pax_out_if.source evt
);

    pax_pkg::cls_t fr_item, bk_item;
    logic          fr_valid, fr_ready;
    logic          bk_valid, bk_ready;

    pax_front u_front
    (
        .hdr        (hdr),
        .item       (fr_item),
        .item_valid (fr_valid),
        .item_ready (fr_ready)
    );

    pax_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (fr_item),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .pop_item   (bk_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready)
    );

    pax_back #(.LENGTH_BITS(LENGTH_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (bk_item),
        .item_valid (bk_valid),
        .item_ready (bk_ready),
        .evt        (evt)
    );

endmodule

@@ tb/pax_parser_checker.sv @@
// checker: watches both channels, predicts the event stream of the pax parser and compares
module pax_parser_checker
(
    input  logic clk,
    input  logic rst_n,
    pax_in_if.sink  hdr_mon,
    pax_out_if.sink evt_mon,
    output int      fail_count,
    output int      pending_events,
    output int      events_seen,
    output int      headers_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  key;
        logic [7:0]  text;
        logic [63:0] num;
        logic [3:0]  err;
        logic        ok;
    } pax_event_t;

    localparam int LEN_BITS = 20;
    localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [63:0] MTIME_LIMIT = 64'h7fff_ffff_ffff_ffff;

    typedef enum logic [1:0] {S_LEN, S_KEY, S_VAL, S_FAULT} pred_phase_t;

    pax_event_t  event_fifo[$];
    pred_phase_t ph;
    logic [63:0] rec_len, rec_pos, acc, val_len;
    int          n_digits, key_pos;
    logic [6:0]  key_cand;
    logic        frac_seen;
    logic [1:0]  cs_cand;
    logic [3:0]  held_err;

    function automatic int name_len(int k);
        int lens[7] = '{4, 8, 3, 3, 4, 5, 10};
        return lens[k];
    endfunction

    function automatic logic [7:0] name_char(int k, int p);
        string names[7] = '{"path", "linkpath", "uid", "gid", "size", "mtime", "hdrcharset"};
        if (p >= names[k].len())
            return 8'h00;
        return names[k][p];
    endfunction

    function automatic logic [7:0] charset_char(int c, int p);
        string cs[2] = '{"BINARY", "UTF-8"};
        if (p >= cs[c].len())
            return 8'h00;
        return cs[c][p];
    endfunction

    function automatic int first_key(logic [6:0] cand);
        for (int k = 0; k < 7; k++)
            if (cand[k])
                return k;
        return 0;
    endfunction

    task automatic clear_record();
        ph = S_LEN;
        rec_len = 0;
        rec_pos = 0;
        n_digits = 0;
        key_pos = 0;
        key_cand = 7'h7f;
        acc = 0;
        val_len = 0;
        frac_seen = 0;
        cs_cand = 2'b11;
    endtask

    task automatic push_event(logic [1:0] kind, int key, logic [7:0] text, logic [63:0] num,
                              logic [3:0] err, logic ok);
        pax_event_t e;
        e.kind = kind;
        e.key = 3'(key);
        e.text = text;
        e.num = num;
        e.err = err;
        e.ok = ok;
        event_fifo.push_back(e);
    endtask

    task automatic predict_byte(logic [7:0] b, logic last);
        logic [3:0]  err;
        logic        done, text, digit;
        int          dkey, k;
        logic [63:0] dnum;
        logic [6:0]  m;
        err = pax_pkg::ERR_NONE;
        done = 0;
        text = 0;
        dkey = 0;
        dnum = 0;
        digit = b >= "0" && b <= "9";
        if (ph == S_LEN)
        begin
            if (digit)
            begin
                if (n_digits < 31)
                    n_digits++;
                rec_len = rec_len * 10 + 64'(b - "0");
                if (rec_len > LEN_MAX)
                    err = pax_pkg::ERR_BAD_LENGTH;
            end
            else if (b == pax_pkg::CH_SPACE)
            begin
                if (n_digits == 0 || rec_len < rec_pos + 3)
                    err = pax_pkg::ERR_BAD_LENGTH;
                else
                    ph = S_KEY;
            end
            else
                err = pax_pkg::ERR_BAD_LENGTH;
            if (rec_pos < LEN_MAX)
                rec_pos++;
        end
        else if (ph == S_KEY || ph == S_VAL)
        begin
            if (rec_pos + 1 == rec_len)
            begin
                if (b != pax_pkg::CH_NEWLINE)
                    err = pax_pkg::ERR_NO_NEWLINE;
                else if (ph == S_KEY)
                    err = pax_pkg::ERR_BAD_KEY;
                else
                begin
                    k = first_key(key_cand);
                    if (k <= 1)
                    begin
                        if (val_len == 0)
                            err = pax_pkg::ERR_BAD_STRING;
                    end
                    else if (k <= 5)
                    begin
                        if (val_len == 0)
                            err = pax_pkg::ERR_BAD_NUMBER;
                        else if (k == 5 && acc > MTIME_LIMIT)
                            err = pax_pkg::ERR_BAD_NUMBER;
                        else
                            dnum = acc;
                    end
                    else if (!((cs_cand[0] && val_len == 6) || (cs_cand[1] && val_len == 5)))
                        err = pax_pkg::ERR_BAD_CHARSET;
                    if (err == pax_pkg::ERR_NONE)
                    begin
                        done = 1;
                        dkey = k;
                        clear_record();
                    end
                end
            end
            else if (ph == S_KEY)
            begin
                if (b == pax_pkg::CH_EQUALS)
                begin
                    m = 0;
                    for (k = 0; k < 7; k++)
                        if (key_cand[k] && name_len(k) == key_pos)
                            m[k] = 1;
                    if (key_pos == 0)
                        err = pax_pkg::ERR_BAD_KEY;
                    else if (m == 0)
                        err = pax_pkg::ERR_UNKNOWN;
                    else
                    begin
                        key_cand = m;
                        ph = S_VAL;
                    end
                end
                else
                begin
                    for (k = 0; k < 7; k++)
                        if (key_pos >= name_len(k) || name_char(k, key_pos) != b)
                            key_cand[k] = 0;
                    if (key_pos < 15)
                        key_pos++;
                end
                rec_pos++;
            end
            else
            begin
                k = first_key(key_cand);
                if (k <= 1)
                begin
                    if (b == 0)
                        err = pax_pkg::ERR_BAD_STRING;
                    else
                        text = 1;
                    if (val_len < LEN_MAX)
                        val_len++;
                end
                else if (k <= 5)
                begin
                    if (k == 5 && frac_seen)
                        ;  // fraction of mtime is dropped
                    else if (k == 5 && b == pax_pkg::CH_DOT)
                        frac_seen = 1;
                    else if (!digit || acc > (64'hffff_ffff_ffff_ffff - 64'(b - "0")) / 10)
                        err = pax_pkg::ERR_BAD_NUMBER;
                    else
                    begin
                        acc = acc * 10 + 64'(b - "0");
                        if (val_len < LEN_MAX)
                            val_len++;
                    end
                end
                else
                begin
                    for (int c = 0; c < 2; c++)
                        if (val_len >= ((c == 0) ? 6 : 5) || charset_char(c, int'(val_len)) != b)
                            cs_cand[c] = 0;
                    if (val_len < LEN_MAX)
                        val_len++;
                end
                dkey = k;
                rec_pos++;
            end
        end
        if (err != pax_pkg::ERR_NONE && held_err == pax_pkg::ERR_NONE)
        begin
            held_err = err;
            ph = S_FAULT;
        end
        if (last)
        begin
            if (held_err != pax_pkg::ERR_NONE)
                push_event(pax_pkg::EV_FINISH, 0, 0, 0, held_err, 0);
            else if (done)
                push_event(pax_pkg::EV_FINISH, dkey, 0, dnum, pax_pkg::ERR_NONE, 1);
            else
                push_event(pax_pkg::EV_FINISH, 0, 0, 0, pax_pkg::ERR_TRUNCATED, 0);
            clear_record();
            held_err = pax_pkg::ERR_NONE;
        end
        else if (held_err == pax_pkg::ERR_NONE)
        begin
            if (done)
                push_event(pax_pkg::EV_RECORD, dkey, 0, dnum, pax_pkg::ERR_NONE, 0);
            else if (text)
                push_event(pax_pkg::EV_TEXT, dkey, b, 0, pax_pkg::ERR_NONE, 0);
        end
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic compare_event();
        pax_event_t e;
        if (event_fifo.size() == 0)
        begin
            report_mismatch("event with nothing expected");
            return;
        end
        e = event_fifo.pop_front();
        if (evt_mon.event_kind !== e.kind || evt_mon.key_code !== e.key ||
            evt_mon.text_byte !== e.text || evt_mon.record_number !== e.num ||
            evt_mon.error_code !== e.err || evt_mon.header_ok !== e.ok)
            report_mismatch($sformatf(
                "got kind %0d key %0d text %h num %0d err %0d ok %0b, want %0d %0d %h %0d %0d %0b",
                evt_mon.event_kind, evt_mon.key_code, evt_mon.text_byte, evt_mon.record_number,
                evt_mon.error_code, evt_mon.header_ok, e.kind, e.key, e.text, e.num, e.err, e.ok));
        if (e.kind == pax_pkg::EV_FINISH)
            headers_seen++;
    endtask

    initial
    begin
        fail_count = 0;
        events_seen = 0;
        headers_seen = 0;
        held_err = pax_pkg::ERR_NONE;
        clear_record();
    end

    assign pending_events = event_fifo.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hdr_mon.valid && hdr_mon.ready)
                predict_byte(hdr_mon.data_byte, hdr_mon.last_byte);
            if (evt_mon.valid && evt_mon.ready)
            begin
                compare_event();
                events_seen++;
            end
        end
    end
endmodule

@@ tb/tb_pax_header_record_parser.sv @@
// testbench top: builds pax header byte streams, drives the parser and gives the verdict
module tb_pax_header_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count, pending_events, events_seen, headers_seen;
    int   bytes_sent = 0;
    int   idle_cycles = 0;
    logic [7:0] stream[$];

    pax_in_if  hdr();
    pax_out_if evt();

    pax_header_record_parser dut (.clk(clk), .rst_n(rst_n), .hdr(hdr), .evt(evt));

    pax_parser_checker checker_i (
        .clk(clk), .rst_n(rst_n), .hdr_mon(hdr), .evt_mon(evt),
        .fail_count(fail_count), .pending_events(pending_events),
        .events_seen(events_seen), .headers_seen(headers_seen)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((hdr.valid && hdr.ready) || (evt.valid && evt.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // sink side: random stall before taking each event
    initial
    begin
        int wait_cycles;
        evt.ready = 0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = $urandom_range(0, 4);
            if (wait_cycles != 0)
            begin
                evt.ready <= 0;
                repeat (wait_cycles) @(negedge clk);
            end
            evt.ready <= 1;
            @(posedge clk);
            while (!evt.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_byte(logic [7:0] b, logic last, int gap);
        if (gap != 0)
        begin
            hdr.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        hdr.valid <= 1;
        hdr.data_byte <= b;
        hdr.last_byte <= last;
        @(posedge clk);
        while (!hdr.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // send the queued stream as one header; busy streams keep valid high
    task automatic send_header(bit bursty);
        int gap;
        for (int i = 0; i < stream.size(); i++)
        begin
            gap = bursty ? 0 : $urandom_range(0, 4);
            send_byte(stream[i], i == stream.size() - 1, gap);
        end
        stream.delete();
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            stream.push_back(s[i]);
    endtask

    // one well formed record "<len> key=value\n" with its length fixed up
    task automatic add_record(string key, string value);
        int body, total;
        string num;
        body = key.len() + value.len() + 3;
        total = body + 1;
        num.itoa(total);
        if (num.len() + body != total)
        begin
            total = body + num.len() + 1;
            num.itoa(total);
            if (num.len() + body != total)
            begin
                total++;
                num.itoa(total);
            end
        end
        add_text({num, " ", key, "=", value, "\n"});
    endtask

    function automatic string rand_digits(int n);
        string s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_text(int n);
        string s = "";
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(1, 255));
            s = {s, string'(c)};
        end
        return s;
    endfunction

    task automatic add_random_record();
        string keys[7] = '{"path", "linkpath", "uid", "gid", "size", "mtime", "hdrcharset"};
        int k;
        k = $urandom_range(0, 6);
        case (k)
            0, 1: add_record(keys[k], rand_text($urandom_range(1, 12)));
            2, 3, 4: add_record(keys[k], rand_digits($urandom_range(1, 20)));
            5: add_record(keys[k], {rand_digits($urandom_range(1, 19)), ".",
                                    rand_digits($urandom_range(0, 5))});
            default: add_record(keys[k], ($urandom_range(0, 1) != 0) ? "UTF-8" : "BINARY");
        endcase
    endtask

    initial
    begin
        hdr.valid = 0;
        hdr.data_byte = 0;
        hdr.last_byte = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: each key, extremes, and each fault kind
        add_record("path", {"a", string'(8'hff), "z"});
        add_record("linkpath", "x");
        add_record("uid", "0");
        add_record("gid", "18446744073709551615");
        add_record("size", "7");
        add_record("mtime", "9223372036854775807.25");
        add_record("hdrcharset", "BINARY");
        send_header(1);
        add_record("hdrcharset", "UTF-8");
        send_header(0);
        add_text("9 uid=12\n");          // final record on last byte
        send_header(1);
        add_text("99999999");            // overlong length
        send_header(0);
        add_text("2 ");                  // short length
        send_header(0);
        add_text("x");                   // non digit in length
        send_header(0);
        add_text("8 uid=1x");            // missing newline
        send_header(0);
        add_text("6 uid\n");             // missing equals
        send_header(0);
        add_text("6 =ab\n");             // empty key
        send_header(0);
        add_text("7 foo=1\n");           // unknown key
        send_header(0);
        add_record("uid", "18446744073709551616");
        send_header(0);
        add_record("mtime", "9223372036854775808");
        send_header(0);
        add_record("size", "");
        send_header(0);
        add_record("path", "");
        send_header(0);
        add_record("path", {"a", string'(8'h00)});
        send_header(0);
        add_record("hdrcharset", "UTF-16");
        send_header(0);
        add_text("12 path=ab");          // truncated
        send_header(0);

        // random headers: mostly well formed records, some corrupted
        while (bytes_sent < 550)
        begin
            repeat ($urandom_range(1, 3))
                add_random_record();
            if ($urandom_range(0, 3) == 0)
                stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0 && stream.size() > 1)
                void'(stream.pop_back());
            send_header($urandom_range(0, 2) == 0);
        end
        hdr.valid <= 0;

        while (pending_events != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d header bytes, checked %0d events over %0d headers",
                 bytes_sent, events_seen, headers_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
